// ----- hdl/sdm_pkg.sv -----
// Package for the set difference block: sizes, payload structs and the
// links that pass between neighbouring cells of the compare chain.
// No dependencies.
package sdm_pkg;

   // Store depth in pairs and width of one value.
   localparam int MAX_PAIRS  = 32;
   localparam int VALUE_BITS = 16;

   // Cell index and pair count widths.
   localparam int IDX_BITS = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CNT_BITS = $clog2(MAX_PAIRS + 1);

   // Controller state codes.
   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_CMP   = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   // One input transfer.
   typedef struct packed {
      value_type a_value;
      value_type b_value;
      logic      last_pair;
   } req_type;

   // One result transfer.
   typedef struct packed {
      value_type kept_value;
      value_type min_kept;
      logic      final_result;
      logic      empty_set;
      logic      overflowed;
   } rsp_type;

   // List A element as it moves towards the head of the chain.
   typedef struct packed {
      value_type a;
      logic      valid;
      logic      hit;
   } a_link_type;

   // List B element as it rotates around the chain.
   typedef struct packed {
      value_type b;
      logic      valid;
   } b_link_type;

   // Controls shared by every cell.
   typedef struct packed {
      logic clear;
      logic compare;
      logic shift;
   } cell_ctrl_type;

endpackage

// ----- hdl/sdm_cell.sv -----
// One cell of the compare chain: holds one A element with its hit flag and
// one B element. Depends on sdm_pkg.
module sdm_cell import sdm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          load_en,
   input  value_type     load_a,
   input  value_type     load_b,
   input  b_link_type    b_prev,
   input  a_link_type    a_next,
   output b_link_type    b_out,
   output a_link_type    a_out
);

   a_link_type a_ff, a_in;
   b_link_type b_ff, b_in;

   // Next state: clear, load, compare with rotation of B, or shift of A.
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (ctrl.clear) begin
         a_in.valid = 1'b0;
         a_in.hit   = 1'b0;
         b_in.valid = 1'b0;
      end else if (load_en) begin
         a_in.a     = load_a;
         a_in.valid = 1'b1;
         a_in.hit   = 1'b0;
         b_in.b     = load_b;
         b_in.valid = 1'b1;
      end else if (ctrl.compare) begin
         a_in.hit = a_ff.hit | (b_ff.valid & (b_ff.b == a_ff.a));
         b_in     = b_prev;
      end else if (ctrl.shift) begin
         a_in = a_next;
      end
   end

   // Valid and hit flags are reset; the values need none.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         a_ff.hit   <= 1'b0;
         b_ff.valid <= 1'b0;
      end else begin
         a_ff.valid <= a_in.valid;
         a_ff.hit   <= a_in.hit;
         b_ff.valid <= b_in.valid;
      end
      a_ff.a <= a_in.a;
      b_ff.b <= b_in.b;
   end

   assign a_out = a_ff;
   assign b_out = b_ff;

endmodule

// ----- hdl/set_difference_with_min.sv -----
// Set difference with minimum: pairs load into a chain of MAX_PAIRS cells, B rotates
// past every A, then A shifts out of the head.
// One pair is taken per cycle while loading.
// Synchronous reset empties the chain and clears the count and overflow flag.
// Depends on sdm_pkg and sdm_cell.
module set_difference_with_min import sdm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] pair_count_ff, pair_count_in;
   logic                ovf_ff, ovf_in;
   logic [IDX_BITS-1:0] step_ff, step_in;
   logic                pend_ff, pend_in;
   value_type           pend_val_ff, pend_val_in;
   value_type           min_ff, min_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   cell_ctrl_type       ctrl;
   logic                req_xfer, load_go, out_free, step_last;
   logic [MAX_PAIRS-1:0] load_en;
   a_link_type          a_link [MAX_PAIRS];
   b_link_type          b_link [MAX_PAIRS];
   a_link_type          head;
   logic                keep;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_xfer  = req_valid & req_ready;
   assign load_go   = req_xfer & (pair_count_ff < CNT_BITS'(MAX_PAIRS));
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign step_last = (step_ff == IDX_BITS'(MAX_PAIRS - 1));
   assign head      = a_link[0];
   assign keep      = head.valid & ~head.hit;

   // Chain of cells; B rotates in a ring, A shifts towards cell 0.
   for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
      b_link_type b_prev;
      a_link_type a_next;

      assign load_en[i] = load_go & (pair_count_ff[IDX_BITS-1:0] == IDX_BITS'(i));
      assign b_prev     = (i == 0) ? b_link[MAX_PAIRS-1] : b_link[(i + MAX_PAIRS - 1) % MAX_PAIRS];
      if (i == MAX_PAIRS - 1) begin : g_tail
         assign a_next = '0;
      end else begin : g_body
         assign a_next = a_link[i + 1];
      end

      sdm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .load_en (load_en[i]),
         .load_a  (req_data.a_value),
         .load_b  (req_data.b_value),
         .b_prev  (b_prev),
         .a_next  (a_next),
         .b_out   (b_link[i]),
         .a_out   (a_link[i])
      );
   end

   // Sequencer: load, compare, scan out the survivors, then the final result.
   always_comb begin
      state_in      = state_ff;
      pair_count_in = pair_count_ff;
      ovf_in        = ovf_ff;
      step_in       = step_ff;
      pend_in       = pend_ff;
      pend_val_in   = pend_val_ff;
      min_in        = min_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ctrl          = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (load_go) begin
                  pair_count_in = pair_count_ff + CNT_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_pair) begin
                  state_in = ST_CMP;
                  step_in  = '0;
               end
            end
         end
         ST_CMP: begin
            ctrl.compare = 1'b1;
            step_in      = step_ff + IDX_BITS'(1);
            if (step_last) begin
               state_in = ST_SCAN;
               step_in  = '0;
            end
         end
         ST_SCAN: begin
            // A survivor behind a pending one needs the output register.
            if (!(keep && pend_ff && !out_free)) begin
               ctrl.shift = 1'b1;
               step_in    = step_ff + IDX_BITS'(1);
               if (keep) begin
                  if (pend_ff) begin
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.kept_value   = pend_val_ff;
                     rsp_data_in.min_kept     = '0;
                     rsp_data_in.final_result = 1'b0;
                     rsp_data_in.empty_set    = 1'b0;
                     rsp_data_in.overflowed   = ovf_ff;
                  end
                  pend_in     = 1'b1;
                  pend_val_in = head.a;
                  if (!pend_ff || (head.a < min_ff)) begin
                     min_in = head.a;
                  end
               end
               if (step_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.kept_value   = pend_ff ? pend_val_ff : '0;
               rsp_data_in.min_kept     = pend_ff ? min_ff : '0;
               rsp_data_in.final_result = 1'b1;
               rsp_data_in.empty_set    = ~pend_ff;
               rsp_data_in.overflowed   = ovf_ff;
               ctrl.clear               = 1'b1;
               pair_count_in            = '0;
               ovf_in                   = 1'b0;
               pend_in                  = 1'b0;
               state_in                 = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers are reset; values and the result payload are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         pair_count_ff <= '0;
         ovf_ff        <= 1'b0;
         step_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pair_count_ff <= pair_count_in;
         ovf_ff        <= ovf_in;
         step_ff       <= step_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_val_ff <= pend_val_in;
      min_ff      <= min_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The pair count never passes the store depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      pair_count_ff <= CNT_BITS'(MAX_PAIRS))
      else $error("pair count beyond store depth");

   // An empty result is always the final one and carries zero values.
   a_empty_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.empty_set) |->
         (rsp_data.final_result && rsp_data.kept_value == '0 && rsp_data.min_kept == '0))
      else $error("empty result is not a clean final result");

   // Only the final result carries a minimum.
   a_min_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.final_result) |-> (rsp_data.min_kept == '0))
      else $error("minimum on a non-final result");

   // Completing a run leaves the count and overflow flag clear for the next list.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free) |=> (pair_count_ff == '0 && !ovf_ff && req_ready))
      else $error("run did not restart cleanly");

endmodule

// ----- verif/set_difference_with_min_tb.sv -----
// Self-checking testbench for set_difference_with_min: sends lists of pairs,
// predicts the kept A elements and their minimum, and checks every result transfer.
// Depends on sdm_pkg and the set_difference_with_min RTL.
module set_difference_with_min_tb;
   import sdm_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 2 * MAX_PAIRS + 8;
   localparam int CYCLE_LIMIT  = 200000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Pairs waiting to be offered, and results still owed by the block.
   req_type pending_pairs[$];
   rsp_type expected_results[$];

   // Idling controls, set per phase by the stimulus process.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_asked     = 0;
   int hold_served    = 0;
   int hold_left      = 0;

   int error_count     = 0;
   int pairs_accepted  = 0;
   int lists_done      = 0;
   int results_checked = 0;
   int overflow_lists  = 0;
   int cycle_count     = 0;

   // Predictor state: the lists loaded so far in the current run.
   value_type a_list [MAX_PAIRS];
   value_type b_list [MAX_PAIRS];
   int        pairs_held    = 0;
   logic      pairs_dropped = 1'b0;

   set_difference_with_min u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("FAIL set_difference_with_min");
         $finish;
      end
   end

   // Store one accepted pair; on the last pair work out the kept elements of A.
   task automatic take_pair(input req_type item);
      rsp_type   held;
      logic      have_held;
      logic      hit;
      value_type least;
      int        kept;
      pairs_accepted++;
      if (pairs_held < MAX_PAIRS) begin
         a_list[pairs_held] = item.a_value;
         b_list[pairs_held] = item.b_value;
         pairs_held++;
      end else begin
         pairs_dropped = 1'b1;
      end
      if (item.last_pair) begin
         kept      = 0;
         least     = '0;
         have_held = 1'b0;
         held      = '0;
         for (int i = 0; i < pairs_held; i++) begin
            hit = 1'b0;
            for (int j = 0; j < pairs_held; j++) begin
               if (b_list[j] == a_list[i]) hit = 1'b1;
            end
            if (!hit) begin
               if (kept == 0 || a_list[i] < least) least = a_list[i];
               // The latest kept element is held back so that it can become the final one.
               if (have_held) expected_results.push_back(held);
               held            = '0;
               held.kept_value = a_list[i];
               held.overflowed = pairs_dropped;
               have_held       = 1'b1;
               kept++;
            end
         end
         if (have_held) begin
            held.min_kept     = least;
            held.final_result = 1'b1;
         end else begin
            held              = '0;
            held.final_result = 1'b1;
            held.empty_set    = 1'b1;
            held.overflowed   = pairs_dropped;
         end
         expected_results.push_back(held);
         lists_done++;
         if (pairs_dropped) overflow_lists++;
         pairs_held    = 0;
         pairs_dropped = 1'b0;
      end
   endtask

   task automatic report_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
   endtask

   // Compare one result transfer with the oldest expectation.
   task automatic check_result(input rsp_type got);
      rsp_type want;
      results_checked++;
      if (expected_results.size() == 0) begin
         error_count++;
         $display("%0t: unexpected result, expected none, actual kept %0d min %0d final %0b",
                  $time, got.kept_value, got.min_kept, got.final_result);
      end else begin
         want = expected_results.pop_front();
         if (got.kept_value !== want.kept_value)
            report_field("kept_value", want.kept_value, got.kept_value);
         if (got.min_kept !== want.min_kept)
            report_field("min_kept", want.min_kept, got.min_kept);
         if (got.final_result !== want.final_result)
            report_field("final_result", want.final_result, got.final_result);
         if (got.empty_set !== want.empty_set)
            report_field("empty_set", want.empty_set, got.empty_set);
         if (got.overflowed !== want.overflowed)
            report_field("overflowed", want.overflowed, got.overflowed);
      end
   endtask

   // Driver: offers queued pairs, idling at random between transfers.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) take_pair(req_data);
         if (!req_valid || req_ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_pairs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here whenever the stimulus asks for one.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_asked;
      end
   end

   // Monitor: checks each result transfer and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_pair(input int a, input int b, input logic last);
      req_type item;
      item.a_value   = value_type'(a);
      item.b_value   = value_type'(b);
      item.last_pair = last;
      pending_pairs.push_back(item);
   endtask

   // Mostly small values so that A and B often share elements, plus full range and extremes.
   function automatic value_type pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 45) return value_type'(int'($urandom_range(6)) - 3);
      if (sel < 85) return value_type'($urandom);
      case ($urandom_range(3))
         0:       return value_type'(-32768);
         1:       return value_type'(32767);
         2:       return value_type'(0);
         default: return value_type'(-1);
      endcase
   endfunction

   task automatic queue_list(input int count);
      for (int k = 0; k < count; k++) queue_pair(pick_value(), pick_value(), k == count - 1);
   endtask

   // Whole lists of random length, now and then past the store depth.
   task automatic queue_random_pairs(input int budget);
      int queued;
      int sel;
      int span;
      queued = 0;
      while (queued < budget) begin
         sel = $urandom_range(99);
         if (sel < 70)      span = $urandom_range(8, 1);
         else if (sel < 90) span = $urandom_range(MAX_PAIRS, 9);
         else               span = $urandom_range(MAX_PAIRS + 8, MAX_PAIRS + 1);
         queue_list(span);
         queued += span;
      end
   endtask

   // Waits until every queued pair is sent and every result has arrived.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_pairs.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed lists: extremes, nothing kept, duplicates, matches at other positions.
      queue_pair(32767, -32768, 1'b1);
      queue_pair(-32768, -32768, 1'b1);
      queue_pair(-32768, 5, 1'b0);
      queue_pair(32767, -1, 1'b0);
      queue_pair(0, 0, 1'b0);
      queue_pair(-1, 7, 1'b1);
      queue_pair(1, 3, 1'b0);
      queue_pair(2, 1, 1'b0);
      queue_pair(3, 2, 1'b1);
      queue_pair(9, 100, 1'b0);
      queue_pair(-4, 100, 1'b0);
      queue_pair(9, -5, 1'b0);
      queue_pair(-4, 0, 1'b0);
      queue_pair(12, 0, 1'b1);
      queue_pair(7, 1, 1'b0);
      queue_pair(8, 7, 1'b1);
      queue_pair(-1, -1, 1'b0);
      queue_pair(2, 3, 1'b1);
      wait_drained();

      // Random lists under each idling pattern.
      queue_random_pairs(40);
      wait_drained();
      send_idle_pct = 68;
      queue_random_pairs(40);
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 68;
      queue_random_pairs(40);
      wait_drained();
      send_idle_pct  = 30;
      recv_stall_pct = 30;
      queue_random_pairs(40);
      wait_drained();

      // Receiver holds off while full and overfull lists keep coming.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_asked     = hold_asked + 1;
      queue_list(MAX_PAIRS);
      queue_list(MAX_PAIRS + 2);
      queue_random_pairs(10);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected results never arrived, first expected kept %0d",
                  $time, expected_results.size(), expected_results[0].kept_value);
      end
      $display("Checked %0d results from %0d lists of %0d pairs; %0d lists overran the store.",
               results_checked, lists_done, pairs_accepted, overflow_lists);
      $display("Ran without idling, with sender gaps, receiver stalls, both, and a long hold-off.");
      if (error_count == 0) begin
         $display("PASS set_difference_with_min");
      end else begin
         $display("FAIL set_difference_with_min");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/sdm_pkg.sv
hdl/sdm_cell.sv
hdl/set_difference_with_min.sv
verif/set_difference_with_min_tb.sv
